[hw/rtl/ssb_pkg.sv]
// ----------------------------------------------------------------------------
// ssb_pkg: spectral subtraction bin shared definitions
// Widths, fixed-point constants and cell data types for the bin datapath.
// ----------------------------------------------------------------------------
package ssb_pkg;

   // sample width and the magnitude fraction bits that follow from it
   localparam int SAMPLE_BITS = 24;
   localparam int MAG_FRAC    = 32 - SAMPLE_BITS;

   // register and input field widths
   localparam int GAIN_BITS = 16;
   localparam int SNR_BITS  = 16;

   // magnitude square root
   localparam int SQ_BITS   = 2 * SAMPLE_BITS;
   localparam int RAD_BITS  = 64;
   localparam int MAG_BITS  = 32;
   localparam int REM_BITS  = MAG_BITS + 3;

   // oversubtraction factor, unsigned Q3.16
   localparam int ALPHA_BITS        = 19;
   localparam int ALPHA_NUM_BITS    = 21;
   localparam int ALPHA_PROD_BITS   = 2 * ALPHA_NUM_BITS;
   localparam int ALPHA_RECIP_SHIFT = 23;
   localparam int ALPHA_RECIP       = (2 ** ALPHA_RECIP_SHIFT + 4) / 5;
   localparam int ALPHA_LOW_SNR     = -1280;
   localparam int ALPHA_HIGH_SNR    = 5120;
   localparam int ALPHA_BIAS        = 1310722;
   localparam int ALPHA_SLOPE       = 192;
   localparam int ALPHA_MAX         = 5 * (2 ** 16);
   localparam int ALPHA_MIN         = 2 ** 16;

   // subtraction and rebuild
   localparam int SUB_PROD_BITS   = ALPHA_BITS + SAMPLE_BITS;
   localparam int SUB_BITS        = SUB_PROD_BITS + MAG_FRAC;
   localparam int FLOOR_PROD_BITS = GAIN_BITS + SAMPLE_BITS;
   localparam int NEWMAG_BITS     = MAG_BITS + 16;
   localparam int M_BITS          = MAG_BITS + 1;
   localparam int NUM_BITS        = SAMPLE_BITS + M_BITS;

   localparam logic [GAIN_BITS-1:0] FLOOR_GAIN_RESET = 16'd131;

   // bin fields that ride along the square root chain
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic [SAMPLE_BITS-1:0]        noise;
      logic [ALPHA_BITS-1:0]         alpha;
   } sqrt_side_type;

   // one square root cell's contents
   typedef struct packed {
      logic                  valid;
      logic [REM_BITS-1:0]   rem;
      logic [MAG_BITS-1:0]   root;
      logic [RAD_BITS-1:0]   rad;
      sqrt_side_type         side;
   } sqrt_data_type;

   // one divider lane
   typedef struct packed {
      logic [MAG_BITS-1:0]    rem;
      logic [SAMPLE_BITS-1:0] low;
      logic [SAMPLE_BITS-1:0] q;
      logic                   neg;
      logic                   ovf;
   } div_lane_type;

   // one divider cell's contents, both lanes share the divisor
   typedef struct packed {
      logic                valid;
      logic [MAG_BITS-1:0] d;
      div_lane_type        re;
      div_lane_type        im;
   } div_data_type;

endpackage

[hw/rtl/ssb_req_if.sv]
// ----------------------------------------------------------------------------
// ssb_req_if: bin input channel
// Valid/ready channel carrying one voice bin with its noise and frame SNR.
// ----------------------------------------------------------------------------
interface ssb_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ssb_pkg::SAMPLE_BITS-1:0] voice_real;
   logic signed [ssb_pkg::SAMPLE_BITS-1:0] voice_imag;
   logic [ssb_pkg::SAMPLE_BITS-1:0]        noise_magnitude;
   logic signed [ssb_pkg::SNR_BITS-1:0]    frame_snr_db;

   modport source (output valid, voice_real, voice_imag, noise_magnitude, frame_snr_db,
                   input ready);
   modport sink (input valid, voice_real, voice_imag, noise_magnitude, frame_snr_db,
                 output ready);
endinterface

[hw/rtl/ssb_rsp_if.sv]
// ----------------------------------------------------------------------------
// ssb_rsp_if: bin result channel
// Valid/ready channel carrying one cleaned bin.
// ----------------------------------------------------------------------------
interface ssb_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ssb_pkg::SAMPLE_BITS-1:0] clean_real;
   logic signed [ssb_pkg::SAMPLE_BITS-1:0] clean_imag;

   modport source (output valid, clean_real, clean_imag, input ready);
   modport sink (input valid, clean_real, clean_imag, output ready);
endinterface

[hw/rtl/ssb_csr_if.sv]
// ----------------------------------------------------------------------------
// ssb_csr_if: floor gain write channel
// Valid/ready write channel for the spectral floor gain register.
// ----------------------------------------------------------------------------
interface ssb_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ssb_pkg::GAIN_BITS-1:0]     floor_gain;

   modport source (output valid, floor_gain, input ready);
   modport sink (input valid, floor_gain, output ready);
endinterface

[hw/rtl/ssb_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// ssb_sqrt_cell: one step of the magnitude square root
// Takes two radicand bits, settles one root bit and hands on to the next cell.
// ----------------------------------------------------------------------------
module ssb_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ssb_pkg::sqrt_data_type cell_in,
   output ssb_pkg::sqrt_data_type cell_out
);

   logic [ssb_pkg::REM_BITS-1:0] partial_value;
   logic [ssb_pkg::REM_BITS-1:0] trial_value;
   logic                         fits;
   ssb_pkg::sqrt_data_type       data_in;
   ssb_pkg::sqrt_data_type       data_ff;

   // bring down two bits and try root*4+1
   always_comb begin
      partial_value = {cell_in.rem[ssb_pkg::REM_BITS-3:0],
                       cell_in.rad[ssb_pkg::RAD_BITS-1 -: 2]};
      trial_value   = ssb_pkg::REM_BITS'({cell_in.root, 2'b01});
      fits          = partial_value >= trial_value;
      data_in       = cell_in;
      data_in.rem   = fits ? (partial_value - trial_value) : partial_value;
      data_in.root  = {cell_in.root[ssb_pkg::MAG_BITS-2:0], fits};
      data_in.rad   = cell_in.rad << 2;
   end

   // cell register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (advance) begin
         data_ff <= data_in;
      end
   end

   assign cell_out = data_ff;

endmodule

[hw/rtl/ssb_div_cell.sv]
// ----------------------------------------------------------------------------
// ssb_div_cell: one step of the phase rebuild division
// Restoring long division step for the real and imaginary lanes.
// ----------------------------------------------------------------------------
module ssb_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ssb_pkg::div_data_type cell_in,
   output ssb_pkg::div_data_type cell_out
);

   ssb_pkg::div_data_type data_in;
   ssb_pkg::div_data_type data_ff;

   // shift in the next numerator bit, subtract the divisor when it fits
   function automatic ssb_pkg::div_lane_type div_step(input ssb_pkg::div_lane_type lane,
                                                      input logic [ssb_pkg::MAG_BITS-1:0] d);
      logic [ssb_pkg::MAG_BITS:0] partial;
      logic [ssb_pkg::MAG_BITS:0] diff;
      logic                       fits;
      ssb_pkg::div_lane_type      result;
      partial = {lane.rem, lane.low[ssb_pkg::SAMPLE_BITS-1]};
      diff    = partial - {1'b0, d};
      fits    = partial >= {1'b0, d};
      result      = lane;
      result.rem  = fits ? diff[ssb_pkg::MAG_BITS-1:0] : partial[ssb_pkg::MAG_BITS-1:0];
      result.q    = {lane.q[ssb_pkg::SAMPLE_BITS-2:0], fits};
      result.low  = lane.low << 1;
      return result;
   endfunction

   always_comb begin
      data_in    = cell_in;
      data_in.re = div_step(cell_in.re, cell_in.d);
      data_in.im = div_step(cell_in.im, cell_in.d);
   end

   // cell register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (advance) begin
         data_ff <= data_in;
      end
   end

   assign cell_out = data_ff;

endmodule

[hw/rtl/spectral_subtraction_bin_core.sv]
// ----------------------------------------------------------------------------
// spectral_subtraction_bin_core: oversubtraction noise removal on one bin
// Magnitude, Berouti subtraction with spectral floor, and phase rebuild.
// ----------------------------------------------------------------------------
// Usage
//   req carries one FFT bin (real, imaginary), its noise magnitude and the
//   frame SNR in dB, Q7.8. rsp returns the cleaned bin, saturated to the
//   sample width. csr writes the spectral floor gain (Q0.16); write it only
//   while no bin is in flight. csr is always ready.
// Timing
//   One bin per cycle sustained while rsp is ready. Between the req transfer
//   and rsp valid lie three front stages, a 32-cell square root chain, four
//   subtraction/rebuild stages, a division chain of one cell per quotient
//   bit, and the output register.
// Reset
//   Clears all pipeline valid bits and the output and skid valid flags; the
//   floor gain returns to 131 (about 0.002).
// Stall
//   A stalled rsp keeps its result while one more result lands in a skid
//   register; once that is full, req.ready drops and the pipeline holds.
// ----------------------------------------------------------------------------
module spectral_subtraction_bin_core (
   input  logic         clock,
   input  logic         reset,
   ssb_req_if.sink      req,
   ssb_rsp_if.source    rsp,
   ssb_csr_if.sink      csr
);

   localparam int SB = ssb_pkg::SAMPLE_BITS;

   logic advance;

   // floor gain register
   logic [ssb_pkg::GAIN_BITS-1:0] floor_gain_ff;

   // stage 0: input register
   logic                          v0_ff;
   logic signed [SB-1:0]          re0_ff, im0_ff;
   logic [SB-1:0]                 noise0_ff;
   logic signed [ssb_pkg::SNR_BITS-1:0] snr0_ff;

   // stage 1: squares and alpha numerator
   logic [SB-1:0]                 abs_re0, abs_im0;
   logic signed [23:0]            alpha_num0;
   logic                          v1_ff;
   logic [ssb_pkg::SQ_BITS-1:0]   sq_re1_ff, sq_im1_ff;
   logic [ssb_pkg::ALPHA_NUM_BITS-1:0] alpha_num1_ff;
   logic                          low1_ff, high1_ff;
   logic signed [SB-1:0]          re1_ff, im1_ff;
   logic [SB-1:0]                 noise1_ff;

   // stage 2: radicand and alpha reciprocal product
   logic                          v2_ff;
   logic [ssb_pkg::RAD_BITS-1:0]  rad2_ff;
   logic [ssb_pkg::ALPHA_PROD_BITS-1:0] alpha_prod2_ff;
   logic                          low2_ff, high2_ff;
   logic signed [SB-1:0]          re2_ff, im2_ff;
   logic [SB-1:0]                 noise2_ff;

   // square root chain
   ssb_pkg::sqrt_data_type        sqrt_chain [0:ssb_pkg::MAG_BITS];
   ssb_pkg::sqrt_data_type        sqrt_tail;

   // stage 4: subtraction and floor products
   logic                          v4_ff;
   logic [ssb_pkg::SUB_PROD_BITS-1:0]   sub4_ff;
   logic [ssb_pkg::FLOOR_PROD_BITS-1:0] floor4_ff;
   logic [ssb_pkg::MAG_BITS-1:0]  mag4_ff;
   logic signed [SB-1:0]          re4_ff, im4_ff;

   // stage 5: new magnitude
   logic [ssb_pkg::SUB_BITS-1:0]  voice_ext4, sub_ext4;
   logic [ssb_pkg::NEWMAG_BITS-1:0] newmag4;
   logic                          v5_ff;
   logic [ssb_pkg::NEWMAG_BITS-1:0] newmag5_ff;
   logic [ssb_pkg::MAG_BITS-1:0]  mag5_ff;
   logic signed [SB-1:0]          re5_ff, im5_ff;

   // stage 6: rounded magnitude and divider operands
   logic [ssb_pkg::NEWMAG_BITS:0] round5;
   logic                          v6_ff;
   logic [ssb_pkg::M_BITS-1:0]    m6_ff;
   logic [SB-1:0]                 ax6_ff, ay6_ff;
   logic [ssb_pkg::MAG_BITS-1:0]  d6_ff;
   logic                          neg_re6_ff, neg_im6_ff;

   // stage 7: numerator products
   logic                          v7_ff;
   logic [ssb_pkg::NUM_BITS-1:0]  prod_re7_ff, prod_im7_ff;
   logic [ssb_pkg::MAG_BITS-1:0]  d7_ff;
   logic                          neg_re7_ff, neg_im7_ff;

   // division chain
   logic [ssb_pkg::NUM_BITS-1:0]  num_re7, num_im7;
   ssb_pkg::div_data_type         div_chain [0:SB];
   ssb_pkg::div_data_type         div_tail;

   // output and skid registers
   logic [SB-1:0]                 clean_re_in, clean_im_in;
   logic                          rsp_valid_ff, skid_valid_ff;
   logic [SB-1:0]                 rsp_real_ff, rsp_imag_ff;
   logic [SB-1:0]                 skid_real_ff, skid_imag_ff;

   // clamp the quotient to the signed sample range and apply the sign
   function automatic logic [SB-1:0] saturate(input logic neg, input logic ovf,
                                              input logic [SB-1:0] q);
      logic [SB-1:0] half;
      half = {1'b1, {(SB-1){1'b0}}};
      if (neg) begin
         if (ovf || (q > half)) begin
            return half;
         end
         return -q;
      end
      if (ovf || q[SB-1]) begin
         return half - 1'b1;
      end
      return q;
   endfunction

   assign advance   = !skid_valid_ff;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   // floor gain write
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_gain_ff <= ssb_pkg::FLOOR_GAIN_RESET;
      end else if (csr.valid) begin
         floor_gain_ff <= csr.floor_gain;
      end
   end

   // stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff     <= req.valid;
         re0_ff    <= req.voice_real;
         im0_ff    <= req.voice_imag;
         noise0_ff <= req.noise_magnitude;
         snr0_ff   <= req.frame_snr_db;
      end
   end

   // stage 1: absolute values squared, alpha = (bias - 192*snr) / 5 numerator
   always_comb begin
      abs_re0    = re0_ff[SB-1] ? SB'(-re0_ff) : SB'(re0_ff);
      abs_im0    = im0_ff[SB-1] ? SB'(-im0_ff) : SB'(im0_ff);
      alpha_num0 = 24'(signed'(ssb_pkg::ALPHA_BIAS))
                 - 24'(signed'(snr0_ff)) * 24'(signed'(ssb_pkg::ALPHA_SLOPE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff         <= v0_ff;
         sq_re1_ff     <= ssb_pkg::SQ_BITS'(abs_re0) * ssb_pkg::SQ_BITS'(abs_re0);
         sq_im1_ff     <= ssb_pkg::SQ_BITS'(abs_im0) * ssb_pkg::SQ_BITS'(abs_im0);
         alpha_num1_ff <= alpha_num0[ssb_pkg::ALPHA_NUM_BITS-1:0];
         low1_ff       <= snr0_ff < 16'(signed'(ssb_pkg::ALPHA_LOW_SNR));
         high1_ff      <= snr0_ff > 16'(signed'(ssb_pkg::ALPHA_HIGH_SNR));
         re1_ff        <= re0_ff;
         im1_ff        <= im0_ff;
         noise1_ff     <= noise0_ff;
      end
   end

   // stage 2: scaled radicand, divide by five through the reciprocal
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff          <= v1_ff;
         rad2_ff        <= ssb_pkg::RAD_BITS'(ssb_pkg::RAD_BITS'(sq_re1_ff)
                           + ssb_pkg::RAD_BITS'(sq_im1_ff)) << (2 * ssb_pkg::MAG_FRAC);
         alpha_prod2_ff <= ssb_pkg::ALPHA_PROD_BITS'(alpha_num1_ff)
                         * ssb_pkg::ALPHA_PROD_BITS'(ssb_pkg::ALPHA_RECIP);
         low2_ff        <= low1_ff;
         high2_ff       <= high1_ff;
         re2_ff         <= re1_ff;
         im2_ff         <= im1_ff;
         noise2_ff      <= noise1_ff;
      end
   end

   // feed of the square root chain with the clamped alpha
   always_comb begin
      sqrt_chain[0].valid      = v2_ff;
      sqrt_chain[0].rem        = '0;
      sqrt_chain[0].root       = '0;
      sqrt_chain[0].rad        = rad2_ff;
      sqrt_chain[0].side.re    = re2_ff;
      sqrt_chain[0].side.im    = im2_ff;
      sqrt_chain[0].side.noise = noise2_ff;
      if (low2_ff) begin
         sqrt_chain[0].side.alpha = ssb_pkg::ALPHA_BITS'(ssb_pkg::ALPHA_MAX);
      end else if (high2_ff) begin
         sqrt_chain[0].side.alpha = ssb_pkg::ALPHA_BITS'(ssb_pkg::ALPHA_MIN);
      end else begin
         sqrt_chain[0].side.alpha =
            alpha_prod2_ff[ssb_pkg::ALPHA_RECIP_SHIFT +: ssb_pkg::ALPHA_BITS];
      end
   end

   for (genvar i = 0; i < ssb_pkg::MAG_BITS; i++) begin : g_sqrt
      ssb_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (sqrt_chain[i]),
         .cell_out (sqrt_chain[i+1])
      );
   end

   assign sqrt_tail = sqrt_chain[ssb_pkg::MAG_BITS];

   // stage 4: alpha*noise and beta*noise
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff     <= sqrt_tail.valid;
         sub4_ff   <= ssb_pkg::SUB_PROD_BITS'(sqrt_tail.side.alpha)
                    * ssb_pkg::SUB_PROD_BITS'(sqrt_tail.side.noise);
         floor4_ff <= ssb_pkg::FLOOR_PROD_BITS'(floor_gain_ff)
                    * ssb_pkg::FLOOR_PROD_BITS'(sqrt_tail.side.noise);
         mag4_ff   <= sqrt_tail.root;
         re4_ff    <= sqrt_tail.side.re;
         im4_ff    <= sqrt_tail.side.im;
      end
   end

   // stage 5: subtract, fall back to the spectral floor when not positive
   always_comb begin
      voice_ext4 = ssb_pkg::SUB_BITS'({mag4_ff, 16'b0});
      sub_ext4   = ssb_pkg::SUB_BITS'(sub4_ff) << ssb_pkg::MAG_FRAC;
      if (voice_ext4 > sub_ext4) begin
         newmag4 = ssb_pkg::NEWMAG_BITS'(voice_ext4 - sub_ext4);
      end else begin
         newmag4 = ssb_pkg::NEWMAG_BITS'(floor4_ff) << ssb_pkg::MAG_FRAC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff      <= v4_ff;
         newmag5_ff <= newmag4;
         mag5_ff    <= mag4_ff;
         re5_ff     <= re4_ff;
         im5_ff     <= im4_ff;
      end
   end

   // stage 6: round to the magnitude scale; a zero bin divides 1 by 2^frac
   assign round5 = (ssb_pkg::NEWMAG_BITS+1)'(newmag5_ff)
                 + (ssb_pkg::NEWMAG_BITS+1)'(17'h08000);

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff      <= v5_ff;
         m6_ff      <= round5[ssb_pkg::NEWMAG_BITS:16];
         neg_re6_ff <= re5_ff[SB-1];
         neg_im6_ff <= im5_ff[SB-1];
         if (mag5_ff == '0) begin
            ax6_ff <= SB'(1);
            ay6_ff <= '0;
            d6_ff  <= ssb_pkg::MAG_BITS'(1) << ssb_pkg::MAG_FRAC;
         end else begin
            ax6_ff <= re5_ff[SB-1] ? SB'(-re5_ff) : SB'(re5_ff);
            ay6_ff <= im5_ff[SB-1] ? SB'(-im5_ff) : SB'(im5_ff);
            d6_ff  <= mag5_ff;
         end
      end
   end

   // stage 7: |x| * M
   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (advance) begin
         v7_ff       <= v6_ff;
         prod_re7_ff <= ssb_pkg::NUM_BITS'(ax6_ff) * ssb_pkg::NUM_BITS'(m6_ff);
         prod_im7_ff <= ssb_pkg::NUM_BITS'(ay6_ff) * ssb_pkg::NUM_BITS'(m6_ff);
         d7_ff       <= d6_ff;
         neg_re7_ff  <= neg_re6_ff;
         neg_im7_ff  <= neg_im6_ff;
      end
   end

   // divider feed: add half the divisor, flag quotients past the sample width
   always_comb begin
      num_re7 = prod_re7_ff + ssb_pkg::NUM_BITS'(d7_ff >> 1);
      num_im7 = prod_im7_ff + ssb_pkg::NUM_BITS'(d7_ff >> 1);
      div_chain[0].valid  = v7_ff;
      div_chain[0].d      = d7_ff;
      div_chain[0].re.ovf = num_re7[ssb_pkg::NUM_BITS-1:SB] >= ssb_pkg::M_BITS'(d7_ff);
      div_chain[0].re.rem = num_re7[SB +: ssb_pkg::MAG_BITS];
      div_chain[0].re.low = num_re7[SB-1:0];
      div_chain[0].re.q   = '0;
      div_chain[0].re.neg = neg_re7_ff;
      div_chain[0].im.ovf = num_im7[ssb_pkg::NUM_BITS-1:SB] >= ssb_pkg::M_BITS'(d7_ff);
      div_chain[0].im.rem = num_im7[SB +: ssb_pkg::MAG_BITS];
      div_chain[0].im.low = num_im7[SB-1:0];
      div_chain[0].im.q   = '0;
      div_chain[0].im.neg = neg_im7_ff;
   end

   for (genvar i = 0; i < SB; i++) begin : g_div
      ssb_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (div_chain[i]),
         .cell_out (div_chain[i+1])
      );
   end

   assign div_tail    = div_chain[SB];
   assign clean_re_in = saturate(div_tail.re.neg, div_tail.re.ovf, div_tail.re.q);
   assign clean_im_in = saturate(div_tail.im.neg, div_tail.im.ovf, div_tail.im.q);

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_valid_ff && rsp.ready) begin
         if (skid_valid_ff) begin
            rsp_real_ff   <= skid_real_ff;
            rsp_imag_ff   <= skid_imag_ff;
            skid_valid_ff <= 1'b0;
         end else if (advance && div_tail.valid) begin
            rsp_real_ff <= clean_re_in;
            rsp_imag_ff <= clean_im_in;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff) begin
         if (advance && div_tail.valid) begin
            rsp_valid_ff <= 1'b1;
            rsp_real_ff  <= clean_re_in;
            rsp_imag_ff  <= clean_im_in;
         end
      end else if (advance && div_tail.valid) begin
         skid_valid_ff <= 1'b1;
         skid_real_ff  <= clean_re_in;
         skid_imag_ff  <= clean_im_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.clean_real = rsp_real_ff;
   assign rsp.clean_imag = rsp_imag_ff;

   // skid entry only fills behind a held result
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid without output valid");

   // a full skid entry freezes the valid bits of stages 0, 1, 2 and 4 to 7
   a_frozen_when_full: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({v0_ff, v1_ff, v2_ff, v4_ff, v5_ff, v6_ff, v7_ff}))
      else $error("pipeline moved while skid entry full");

   // square root remainder never exceeds twice the root
   a_sqrt_remainder: assert property (@(posedge clock) disable iff (reset)
      sqrt_tail.valid |-> (sqrt_tail.rem <= ssb_pkg::REM_BITS'({sqrt_tail.root, 1'b0})))
      else $error("square root remainder out of bound");

   // real lane division remainder stays below the divisor when no overflow
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (div_tail.valid && !div_tail.re.ovf) |-> (div_tail.re.rem < div_tail.d))
      else $error("division remainder not below divisor");

endmodule

[verif/tb_spectral_subtraction_bin_core.sv]
// ----------------------------------------------------------------------------
// tb_spectral_subtraction_bin_core: bin subtraction core testbench
// Streams voice bins through the core, with random gaps on the bin input and
// stalls on the result side. Each cleaned bin is compared with a fixed-point
// predictor of the oversubtraction and floor math. The floor gain is changed
// between phases, always while no bin is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_spectral_subtraction_bin_core;

   localparam int SB = ssb_pkg::SAMPLE_BITS;
   localparam int LATENCY = 40 + ssb_pkg::SAMPLE_BITS;
   localparam longint CYCLE_LIMIT = 400000;

   // one cleaned bin
   typedef struct {
      logic [SB-1:0] re;
      logic [SB-1:0] im;
   } clean_bin_type;

   // predicts cleaned bins and checks them in order
   class bin_scoreboard;
      clean_bin_type pending_bins[$];
      logic [ssb_pkg::GAIN_BITS-1:0] gain;
      int mismatch_count;

      function new();
         gain = ssb_pkg::FLOOR_GAIN_RESET;
         mismatch_count = 0;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function logic [SB-1:0] clamp(bit neg, longint unsigned q);
         longint unsigned half;
         half = 64'd1 << (SB - 1);
         if (neg) begin
            if (q > half) q = half;
            return SB'(-q);
         end
         if (q > half - 1) q = half - 1;
         return SB'(q);
      endfunction

      function logic [SB-1:0] scale_part(longint x, longint unsigned m,
                                         longint unsigned mag);
         longint unsigned ax;
         ax = (x < 0) ? longint'(-x) : longint'(x);
         return clamp(x < 0, (ax * m + (mag >> 1)) / mag);
      endfunction

      // berouti subtraction with spectral floor, phase kept
      function void note_bin(logic signed [SB-1:0] vr,
                             logic signed [SB-1:0] vi,
                             logic [SB-1:0] noise,
                             logic signed [ssb_pkg::SNR_BITS-1:0] snr);
         longint re, im, s;
         longint unsigned alpha, mag, vs, sub, newmag, m;
         clean_bin_type c;
         re = vr;
         im = vi;
         s = snr;
         if (s < ssb_pkg::ALPHA_LOW_SNR) alpha = ssb_pkg::ALPHA_MAX;
         else if (s > ssb_pkg::ALPHA_HIGH_SNR) alpha = ssb_pkg::ALPHA_MIN;
         else alpha = (1310720 - 192 * s + 2) / 5;
         mag = int_sqrt(longint'(re * re + im * im) << (2 * ssb_pkg::MAG_FRAC));
         vs = mag << 16;
         sub = (alpha * longint'(noise)) << ssb_pkg::MAG_FRAC;
         if (vs > sub) newmag = vs - sub;
         else newmag = (longint'(gain) * longint'(noise)) << ssb_pkg::MAG_FRAC;
         m = (newmag + (64'd1 << 15)) >> 16;
         if (mag == 0) begin
            c.re = clamp(1'b0, (m + ((64'd1 << ssb_pkg::MAG_FRAC) >> 1)) >> ssb_pkg::MAG_FRAC);
            c.im = '0;
         end else begin
            c.re = scale_part(re, m, mag);
            c.im = scale_part(im, m, mag);
         end
         pending_bins.push_back(c);
      endfunction

      function void check_bin(logic [SB-1:0] re, logic [SB-1:0] im);
         clean_bin_type e;
         if (pending_bins.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result re=%0h im=%0h", re, im);
            return;
         end
         e = pending_bins.pop_front();
         if (e.re !== re || e.im !== im) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected re=%0h im=%0h, got re=%0h im=%0h",
                        e.re, e.im, re, im);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   longint cycle_count;
   bit stall_enable;
   int stall_count;

   ssb_req_if req ();
   ssb_rsp_if rsp ();
   ssb_csr_if csr ();

   bin_scoreboard board;

   spectral_subtraction_bin_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result monitor, checks each transfer
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_bin(rsp.clean_real, rsp.clean_imag);
   end

   // result side stalls, mostly short with a few long ones
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_count <= 0;
      end else if (!stall_enable) begin
         rsp.ready <= 1'b1;
      end else if (stall_count > 0) begin
         rsp.ready <= 1'b0;
         stall_count <= stall_count - 1;
      end else if (r < 2) begin
         rsp.ready <= 1'b0;
         stall_count <= int'($urandom_range(8, 40));
      end else if (r < 5) begin
         rsp.ready <= 1'b0;
      end else if (r < 25) begin
         rsp.ready <= ~rsp.ready;
      end else if (r < 80) begin
         rsp.ready <= 1'b1;
      end
   end

   function int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one bin transfer, then a random gap when gaps is set
   task automatic send_bin(logic [SB-1:0] vr, logic [SB-1:0] vi,
                           logic [SB-1:0] noise, logic [ssb_pkg::SNR_BITS-1:0] snr,
                           bit gaps);
      int g;
      req.valid <= 1'b1;
      req.voice_real <= vr;
      req.voice_imag <= vi;
      req.noise_magnitude <= noise;
      req.frame_snr_db <= snr;
      do @(posedge clock); while (!req.ready);
      board.note_bin(vr, vi, noise, snr);
      g = gaps ? gap_length() : 0;
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic end_stream();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_bins();
      while (board.pending_bins.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_gain(logic [ssb_pkg::GAIN_BITS-1:0] g);
      csr.valid <= 1'b1;
      csr.floor_gain <= g;
      do @(posedge clock); while (!csr.ready);
      board.gain = g;
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   // random bin, mostly magnitudes near the noise so that both branches occur
   task automatic send_random_bin(bit gaps);
      logic [SB-1:0] vr, vi, noise;
      logic [ssb_pkg::SNR_BITS-1:0] snr;
      int mode;
      mode = $urandom_range(0, 9);
      vr = SB'($urandom);
      vi = SB'($urandom);
      if (mode < 4) begin
         vr = SB'($signed(vr) >>> $urandom_range(0, 20));
         vi = SB'($signed(vi) >>> $urandom_range(0, 20));
      end
      if (mode == 4) vi = '0;
      if (mode == 5) begin
         vr = '0;
         vi = '0;
      end
      noise = SB'($urandom);
      if (mode < 7) noise = noise >> $urandom_range(0, 23);
      if (mode < 3) noise = noise >> 4;
      case ($urandom_range(0, 3))
         0: snr = ssb_pkg::SNR_BITS'($urandom);
         1: snr = ssb_pkg::SNR_BITS'($urandom_range(0, 6400) - 1280);
         2: snr = ssb_pkg::SNR_BITS'($urandom_range(0, 8) + ssb_pkg::ALPHA_LOW_SNR - 4);
         default: snr = ssb_pkg::SNR_BITS'($urandom_range(0, 8) + ssb_pkg::ALPHA_HIGH_SNR - 4);
      endcase
      send_bin(vr, vi, noise, snr, gaps);
   endtask

   initial begin
      logic [ssb_pkg::GAIN_BITS-1:0] gains[5];
      board = new();
      cycle_count = 0;
      stall_enable = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.voice_real = '0;
      req.voice_imag = '0;
      req.noise_magnitude = '0;
      req.frame_snr_db = '0;
      csr.valid = 1'b0;
      csr.floor_gain = '0;
      rsp.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, zero bin, floor branch, snr breakpoints
      send_bin(24'h7FFFFF, 24'h7FFFFF, 24'h0, 16'h7FFF, 1'b0);
      send_bin(24'h800000, 24'h800000, 24'h0, 16'h8000, 1'b0);
      send_bin(24'h800000, 24'h7FFFFF, 24'h000100, 16'h0000, 1'b0);
      send_bin(24'h0, 24'h0, 24'h0, 16'h0, 1'b0);
      send_bin(24'h0, 24'h0, 24'hFFFFFF, 16'h8000, 1'b0);
      send_bin(24'h0, 24'h0, 24'h123456, 16'h1400, 1'b0);
      send_bin(24'h001000, 24'hFFF000, 24'hFFFFFF, 16'h0000, 1'b0);
      send_bin(24'h000400, 24'h000000, 24'h000100, 16'hFB00, 1'b0);
      send_bin(24'h000400, 24'h000000, 24'h000100, 16'hFAFF, 1'b0);
      send_bin(24'h000400, 24'h000000, 24'h000100, 16'h1400, 1'b0);
      send_bin(24'h000400, 24'h000000, 24'h000100, 16'h1401, 1'b0);
      send_bin(24'h000400, 24'h000000, 24'h000100, 16'h0A00, 1'b0);
      send_bin(24'h000003, 24'hFFFFFD, 24'h000001, 16'h0001, 1'b0);
      send_bin(24'h000001, 24'h000000, 24'h000000, 16'hFFFF, 1'b0);
      send_bin(24'hFFFFFF, 24'h000001, 24'h000000, 16'h1400, 1'b0);
      send_bin(24'h7FFFFF, 24'h000000, 24'hFFFFFF, 16'h1401, 1'b0);
      send_bin(24'h555555, 24'hAAAAAA, 24'h555555, 16'h5555, 1'b0);
      send_bin(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 16'hAAAA, 1'b0);
      end_stream();
      drain_bins();

      gains[0] = 16'hFFFF;
      gains[1] = 16'h0000;
      gains[2] = 16'h8000;
      gains[3] = 16'h0001;
      gains[4] = 16'h5A5A;
      write_gain(gains[0]);
      send_bin(24'h0, 24'h0, 24'hFFFFFF, 16'h0, 1'b0);
      send_bin(24'h000010, 24'hFFFFF0, 24'hFFFFFF, 16'h8000, 1'b0);
      send_bin(24'h000001, 24'h000001, 24'h7FFFFF, 16'h0, 1'b0);
      end_stream();
      drain_bins();

      // random phases with different floor gains
      stall_enable = 1'b1;
      for (int p = 0; p < 6; p++) begin
         if (p > 0) write_gain(p < 5 ? gains[p] : 16'($urandom));
         for (int i = 0; i < 255; i++) send_random_bin(i < 200);
         end_stream();
         drain_bins();
      end
      write_gain(ssb_pkg::FLOOR_GAIN_RESET);
      for (int i = 0; i < 30; i++) send_random_bin(1'b1);
      end_stream();
      drain_bins();

      if (board.mismatch_count == 0 && board.pending_bins.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
